// File: design/tovm_pkg.sv
// package: shared types, constants and codes for the two-operand execute core
`timescale 1ns / 1ps
package tovm_pkg;
  localparam int MEM_WORDS = 1024;
  localparam int PC_STEP   = 20;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int QDEPTH    = 2;

  localparam logic [3:0] OP_NOP = 4'd0;
  localparam logic [3:0] OP_MOV = 4'd1;
  localparam logic [3:0] OP_ADD = 4'd2;
  localparam logic [3:0] OP_SUB = 4'd3;
  localparam logic [3:0] OP_MUL = 4'd4;
  localparam logic [3:0] OP_DIV = 4'd5;
  localparam logic [3:0] OP_CMP = 4'd6;
  localparam logic [3:0] OP_JMP = 4'd7;
  localparam logic [3:0] OP_JE  = 4'd8;
  localparam logic [3:0] OP_JNE = 4'd9;
  localparam logic [3:0] OP_JG  = 4'd10;
  localparam logic [3:0] OP_JL  = 4'd11;
  localparam logic [3:0] OP_OUT = 4'd12;
  localparam logic [3:0] OP_HLT = 4'd13;

  localparam logic [1:0] KIND_REG = 2'd0;
  localparam logic [1:0] KIND_MEM = 2'd2;

  localparam logic [1:0] STOP_NONE = 2'd0;
  localparam logic [1:0] STOP_HLT  = 2'd1;
  localparam logic [1:0] STOP_DIV0 = 2'd2;

  localparam int ZF_BIT = 0;
  localparam int NF_BIT = 1;

  // classified instruction handed from front to back
  typedef struct packed {
    logic [3:0]  op;
    logic [1:0]  k1;
    logic [31:0] o1;
    logic [1:0]  k2;
    logic [31:0] o2;
  } instr_t;

  typedef struct packed {
    logic [15:0] pc_after;
    logic [1:0]  stop_cause;
    logic        print_valid;
    logic [31:0] print_value;
    logic [1:0]  flags_after;
  } result_t;
endpackage

// File: design/tovm_front.sv
// front end: accepts requests into a short queue
`timescale 1ns / 1ps
module tovm_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tovm_pkg::instr_t in_item,
  output logic            q_valid,
  input  logic            q_ready,
  output tovm_pkg::instr_t q_item
);
  import tovm_pkg::*;
  instr_t buffer [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wr_ptr, rd_ptr;
  logic [$clog2(QDEPTH):0] count;
  logic push, pop;

  assign in_ready = (count != QDEPTH[$clog2(QDEPTH):0]);
  assign q_valid  = (count != '0);
  assign q_item   = buffer[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) buffer[wr_ptr] <= in_item;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + {{$clog2(QDEPTH){1'b0}}, push} - {{$clog2(QDEPTH){1'b0}}, pop};
    end
  end
endmodule

// File: design/tovm_div.sv
// radix-2 signed divider, one quotient bit per cycle
`timescale 1ns / 1ps
module tovm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [31:0] rem, quo, den;
  logic [5:0]  cnt;
  logic        neg, busy;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, den};

  // shift-subtract iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= '0;
        quo  <= dividend[31] ? 32'd0 - dividend : dividend;
        den  <= divisor[31] ? 32'd0 - divisor : divisor;
        neg  <= dividend[31] ^ divisor[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? 32'd0 - quo : quo;
endmodule

// File: design/tovm_back.sv
// back end: sequencer holding machine state, executes one instruction at a time
`timescale 1ns / 1ps
module tovm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  tovm_pkg::instr_t q_item,
  output logic             res_valid,
  input  logic             res_ready,
  output tovm_pkg::result_t res_item
);
  import tovm_pkg::*;
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]  state;
  logic [31:0] regs [16];
  logic [31:0] mem [MEM_WORDS];
  logic [MEM_AW-1:0] clr_addr;
  logic [1:0]  flags;
  logic [15:0] pc;
  instr_t      cur;
  logic [31:0] mem_a, mem_b, a, b, res, prod;
  logic        mem_we;
  logic [MEM_AW-1:0] mem_wa;
  logic [31:0] mem_wd;
  logic        div_start, div_done;
  logic [31:0] div_q;
  logic        wr_en;
  logic [31:0] wr_val;
  logic        set_fl;

  tovm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(a), .divisor(b),
    .done(div_done), .quotient(div_q)
  );

  assign q_ready = (state == S_IDLE) && !res_valid;

  // data store: two read ports, one write port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_a <= mem[cur.o1[MEM_AW-1:0]];
    mem_b <= mem[cur.o2[MEM_AW-1:0]];
  end

  // operand selection
  always_comb begin
    case (cur.k1)
      KIND_REG: a = regs[cur.o1[3:0]];
      KIND_MEM: a = mem_a;
      default:  a = cur.o1;
    endcase
    case (cur.k2)
      KIND_REG: b = regs[cur.o2[3:0]];
      KIND_MEM: b = mem_b;
      default:  b = cur.o2;
    endcase
  end

  // write-back, flag selection, data store write port and divider start
  always_comb begin
    wr_en  = 1'b0;
    wr_val = '0;
    set_fl = 1'b0;
    res    = '0;
    case (state)
      S_EXEC: begin
        case (cur.op)
          OP_MOV: begin wr_en = 1'b1; wr_val = b; end
          OP_ADD: begin wr_en = 1'b1; res = a + b; wr_val = res; set_fl = 1'b1; end
          OP_SUB: begin wr_en = 1'b1; res = a - b; wr_val = res; set_fl = 1'b1; end
          OP_CMP: begin res = a - b; set_fl = 1'b1; end
          default: ;
        endcase
      end
      S_MUL: begin wr_en = 1'b1; res = prod; wr_val = prod; set_fl = 1'b1; end
      S_DIV: begin
        if (div_done) begin wr_en = 1'b1; res = div_q; wr_val = div_q; set_fl = 1'b1; end
      end
      default: ;
    endcase
    mem_we = (state == S_CLEAR) || (wr_en && cur.k1 == KIND_MEM);
    mem_wa = (state == S_CLEAR) ? clr_addr : cur.o1[MEM_AW-1:0];
    mem_wd = (state == S_CLEAR) ? 32'd0 : wr_val;
    div_start = (state == S_EXEC) && (cur.op == OP_DIV) && (b != 32'd0);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      flags     <= '0;
      pc        <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < 16; i++) regs[i] <= '0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (wr_en && cur.k1 == KIND_REG) regs[cur.o1[3:0]] <= wr_val;
      if (set_fl) flags <= {res[31], res == 32'd0};
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == MEM_AW'(MEM_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid && q_ready) begin
            cur   <= q_item;
            state <= S_READ;
          end
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          res_item.stop_cause  <= (cur.op == OP_HLT) ? STOP_HLT :
                                  ((cur.op == OP_DIV) && (b == 32'd0)) ? STOP_DIV0 :
                                  STOP_NONE;
          res_item.print_valid <= (cur.op == OP_OUT);
          res_item.print_value <= (cur.op == OP_OUT) ? a : '0;
          case (cur.op)
            OP_MUL: begin prod <= a * b; state <= S_MUL; end
            OP_DIV: state <= (b == 32'd0) ? S_DONE : S_DIV;
            default: state <= S_DONE;
          endcase
          case (cur.op)
            OP_JMP: pc <= a[15:0];
            OP_JE:  pc <= flags[ZF_BIT] ? a[15:0] : pc + PC_STEP[15:0];
            OP_JNE: pc <= !flags[ZF_BIT] ? a[15:0] : pc + PC_STEP[15:0];
            OP_JG:  pc <= (flags == 2'b00) ? a[15:0] : pc + PC_STEP[15:0];
            OP_JL:  pc <= flags[NF_BIT] ? a[15:0] : pc + PC_STEP[15:0];
            OP_HLT: ;
            OP_DIV: begin
              if (b != 32'd0) pc <= pc + PC_STEP[15:0];
            end
            default: pc <= pc + PC_STEP[15:0];
          endcase
        end
        S_MUL: state <= S_DONE;
        S_DIV: if (div_done) state <= S_DONE;
        S_DONE: begin
          res_item.pc_after    <= pc;
          res_item.flags_after <= flags;
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: design/two_operand_vm_execute_core.sv
// top level: two-operand instruction execute core
// sequence: the back end takes a queued request through read, execute and
// finish states, with a multiply state for mul and a wait on the radix-2
// divider for div, skipped on division by zero; one instruction at a time is
// taken, only while the back end is idle and its last result has been accepted
// reset: rst clears registers, flags and pc, then a clearing pass zeroes every
// data store word before the first request is taken
`timescale 1ns / 1ps
module two_operand_vm_execute_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[3:0], first_kind[5:4], first_operand[37:6], second_kind[39:38],
  // second_operand[71:40]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pc_after[15:0], stop_cause[17:16], print_valid[18], print_value[50:19],
  // flags_after[52:51], zero fill
  output logic [55:0] m_axis_tdata
);
  import tovm_pkg::*;
  instr_t  in_item, q_item;
  result_t res;
  logic    q_valid, q_ready;

  assign in_item.op = s_axis_tdata[3:0];
  assign in_item.k1 = s_axis_tdata[5:4];
  assign in_item.o1 = s_axis_tdata[37:6];
  assign in_item.k2 = s_axis_tdata[39:38];
  assign in_item.o2 = s_axis_tdata[71:40];

  tovm_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  tovm_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_item(res)
  );

  assign m_axis_tdata = {3'b000, res.flags_after, res.print_value, res.print_valid,
                         res.stop_cause, res.pc_after};
endmodule

// File: design/tovm_checker.sv
// checker: port-level properties of the execute core, bound to the top level
`timescale 1ns / 1ps
module tovm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [71:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  // request held while waiting
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("request changed while waiting");
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  // stop cause is never the unused code
  a_stop: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[17:16] != 2'd3)
    else $error("bad stop cause");
  // print only when running
  a_print: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[18] |-> m_axis_tdata[17:16] == 2'd0)
    else $error("print on stop");
  // no result right after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result after reset");
endmodule

bind two_operand_vm_execute_core tovm_checker u_checker (.*);
